/* rtl/mavg_pkg.sv */
package mavg_pkg;

  // Configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE   = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 7'd50;

  // Top-level sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } seq_state_t;

  // Serial divider
  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIX  = 3'b100
  } div_state_t;

  // Window store requests
  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } win_req_t;

endpackage

/* rtl/mavg_div.sv */
module mavg_div
  import mavg_pkg::*;
#(
  parameter int W  = 24,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          signed_mode,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quotient
);

  localparam int CW = $clog2(W + 1);

  div_state_t    state;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic          neg_in;

  // restoring step: one quotient bit per cycle, MSB first
  assign trial  = {rem, quotient[W-1]};
  assign diff   = trial - {1'b0, divisor};
  assign ge     = (trial >= {1'b0, divisor});
  assign neg_in = signed_mode & dividend[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_RUN;
            cnt   <= CW'(W);
          end
        end
        D_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= D_FIX;
        end
        D_FIX: begin
          state <= D_IDLE;
          done  <= 1'b1;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        if (start) begin
          neg      <= neg_in;
          quotient <= neg_in ? (~dividend + 1'b1) : dividend;
          rem      <= '0;
        end
      end
      D_RUN: begin
        rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quotient <= {quotient[W-2:0], ge};
      end
      D_FIX: begin
        if (neg) quotient <= ~quotient + 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_run_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == D_RUN) |-> (cnt != '0))
    else $error("divider running with zero step count");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == D_FIX))
    else $error("divider done without sign fix step");

  a_start_to_run: assert property (@(posedge clk) disable iff (rst)
    (state == D_IDLE && start) |=> (state == D_RUN && cnt == CW'(W)))
    else $error("divider did not load step count");
`endif

endmodule

/* rtl/mavg_window.sv */
module mavg_window
  import mavg_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int W     = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  win_req_t                   req,
  input  logic [W-1:0]               wdata,
  input  logic [$clog2(DEPTH):0]     len,
  output logic [W-1:0]               old_sample
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LEN_W = AW + 1;

  logic [W-1:0]     mem [DEPTH];
  logic [AW-1:0]    pos;
  logic             full;
  logic [W-1:0]     rd_data;
  logic             rd_full;
  logic [LEN_W-1:0] pos_inc;
  logic             wrap;

  // slots fill in order from zero after a clear, so one flag tells
  // whether the slot at pos has been written yet
  assign pos_inc    = {1'b0, pos} + 1'b1;
  assign wrap       = (pos_inc >= len);
  assign old_sample = rd_full ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      pos  <= '0;
      full <= 1'b0;
    end else if (req.wr) begin
      pos <= wrap ? '0 : pos_inc[AW-1:0];
      if (wrap) full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_full <= 1'b0;
    end else if (req.rd) begin
      rd_full <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) rd_data <= mem[pos];
    if (req.wr) mem[pos] <= wdata;
  end

`ifndef SYNTHESIS
  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, pos} < len))
    else $error("write position outside window");

  a_full_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (!full && $past(!full) && !$past(req.clr) && !$past(rst)) |-> (pos != '0 || !$past(req.wr)))
    else $error("window wrapped without setting full");

  a_rd_wr_apart: assert property (@(posedge clk) disable iff (rst)
    !(req.rd && req.wr))
    else $error("window read and write in the same cycle");
`endif

endmodule

/* rtl/moving_average_filter.sv */
// Recursive moving average over the last N samples.
//
// Sample channel: sample_valid / sample_stall / sample_bits. A transaction
// completes on a clock edge with sample_valid high and sample_stall low.
// Average channel: average_valid / average_stall / average_bits, same rule.
// Each sample transaction yields exactly one average transaction.
//
// Config: write_enable, reg_index, write_data. Index 0 is window_length
// (0 acts as 1, values above MAX_WINDOW saturate), index 1 is signed_mode.
// Any write clears the window and the running average; write only when idle.
//
// Timing: after the sample transaction the sample is read in, divided and then
// loaded into the output register; a new sample is taken only once the
// sequencer is back in idle, after that load. The rate is set by the two
// bit-serial dividers (x/N and oldest/N run side by side, one bit a cycle).
// The result sits in an output register: a stalled receiver does not keep
// the next sample out, only the following result waits for the register.
// Reset (sync, active high) gives N=50, unsigned, empty window, average 0.
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic [SAMPLE_WIDTH-1:0] sample_bits,
  output logic                    average_valid,
  input  logic                    average_stall,
  output logic [SAMPLE_WIDTH-1:0] average_bits,
  input  logic                    write_enable,
  input  logic [CFG_INDEX_W-1:0]  reg_index,
  input  logic [CFG_DATA_W-1:0]   write_data
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int LEN_W = $clog2(MAX_WINDOW) + 1;

  seq_state_t       state;
  logic [CFG_DATA_W-1:0] window_length;
  logic             signed_mode;
  logic [LEN_W-1:0] len;
  logic [W-1:0]     sample;
  logic [W-1:0]     avg;
  logic [W-1:0]     avg_next;
  logic [W-1:0]     old_sample;
  logic [W-1:0]     quot_new;
  logic [W-1:0]     quot_old;
  logic             done_new;
  logic             done_old;
  logic             in_take;
  logic             out_free;
  win_req_t         win_req;

  // effective window length
  always_comb begin
    if (window_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(window_length);
    end
  end

  assign sample_stall = (state != S_IDLE);
  assign in_take      = sample_valid && !sample_stall;
  assign out_free     = !average_valid || !average_stall;
  assign avg_next     = avg + quot_new - quot_old;

  // read the departing slot on acceptance, overwrite it in the following cycle
  assign win_req.clr = write_enable;
  assign win_req.rd  = in_take;
  assign win_req.wr  = (state == S_READ);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      signed_mode   <= 1'b0;
    end else if (write_enable) begin
      unique case (reg_index)
        CFG_WINDOW_LENGTH: window_length <= write_data;
        CFG_SIGNED_MODE:   signed_mode   <= write_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, running average and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      avg           <= '0;
      average_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_take) state <= S_READ;
        S_READ: state <= S_DIV;
        S_DIV: begin
          if (done_new) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // any register write clears the average
      if (write_enable) begin
        avg <= '0;
      end else if (state == S_DIV && done_new) begin
        avg <= avg_next;
      end
      // load a fresh average, or drop valid once the receiver takes it
      if (state == S_EMIT && out_free) begin
        average_valid <= 1'b1;
      end else if (!average_stall) begin
        average_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) sample <= sample_bits;
    if (state == S_EMIT && out_free) average_bits <= avg;
  end

  mavg_window #(
    .DEPTH (MAX_WINDOW),
    .W     (W)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .req        (win_req),
    .wdata      (sample),
    .len        (len),
    .old_sample (old_sample)
  );

  mavg_div #(
    .W  (W),
    .DW (LEN_W)
  ) u_div_new (
    .clk         (clk),
    .rst         (rst),
    .start       (state == S_READ),
    .signed_mode (signed_mode),
    .dividend    (sample),
    .divisor     (len),
    .done        (done_new),
    .quotient    (quot_new)
  );

  mavg_div #(
    .W  (W),
    .DW (LEN_W)
  ) u_div_old (
    .clk         (clk),
    .rst         (rst),
    .start       (state == S_READ),
    .signed_mode (signed_mode),
    .dividend    (old_sample),
    .divisor     (len),
    .done        (done_old),
    .quotient    (quot_old)
  );

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (done_new == done_old))
    else $error("dividers out of step");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    done_new |-> (state == S_DIV))
    else $error("divider finished outside divide phase");

  a_take_to_read: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_READ))
    else $error("accepted sample did not start window access");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (average_valid && average_bits == $past(avg)))
    else $error("average not loaded into output register");
`endif

endmodule
